FILE: hw/rtl/pulse_flow_meter_defines.svh
// Assertion macros for the flow-meter pulse counter.
// Each macro expects clk_i and rst_ni to be present in the module that uses it.
`ifndef PULSE_FLOW_METER_DEFINES_SVH
`define PULSE_FLOW_METER_DEFINES_SVH

// Clocked assertion, inactive while reset is asserted.
`define PFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define PFM_ASSERT_IMP(label, ante, cons, msg) \
  `PFM_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: hw/rtl/pfm_pkg.sv
// Package for the flow-meter pulse counter: widths, command and register codes,
// fixed-point constants and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package pfm_pkg;

  // Field widths.
  localparam int TIME_W  = 48;
  localparam int CNT32_W = 32;
  localparam int FLOW_W  = 32;
  localparam int TOT_W   = 48;
  localparam int PPL_W   = 24;
  localparam int SMPL_W  = 16;
  localparam int CMD_W   = 2;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 32;

  // Liters in Q16.16 come from (pulses << 24) divided by the pulse scale.
  localparam int LIT_W   = CNT32_W + PPL_W;
  // Microseconds per minute, and the width of that constant.
  localparam int K_W     = 26;
  localparam logic [K_W-1:0] US_PER_MIN = K_W'(60000000);
  localparam int PROD_W  = LIT_W + K_W;
  // The shared adder covers the widest operand, the liters-times-constant product.
  localparam int ALU_W   = PROD_W;

  // First-window length in microseconds is the millisecond setting times 1000.
  localparam int FDT_W   = 26;
  localparam logic [FDT_W-1:0] US_PER_MS = FDT_W'(1000);

  // Iteration counter and its start values.
  localparam int CNT_W   = 6;
  localparam logic [CNT_W-1:0] DIV_L_LAST = CNT_W'(LIT_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(K_W - 1);
  localparam logic [CNT_W-1:0] DIV_F_LAST = CNT_W'(FLOW_W - 1);

  localparam logic [FLOW_W-1:0] FLOW_MAX  = '1;
  localparam logic [TOT_W-1:0]  TOTAL_MAX = '1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WINDOW = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_GLITCH = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SAMPLE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PPL    = 2'd2;
  localparam logic [CIDX_W-1:0] REG_WIN_EN = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_DT,
    ST_DIV_L,
    ST_MUL,
    ST_OVF,
    ST_DIV_F,
    ST_TOTAL,
    ST_DONE
  } pfm_state_e;

endpackage

FILE: hw/rtl/pulse_flow_meter.sv
// Flow-meter pulse counter with glitch filter around one shared 82-bit adder; uses pfm_pkg.
// Edge: edge-check state, then done; clear or unused commands go straight to done.
// Enabled window tick: window-length state, 56 liter-division and 26 multiply steps, overflow
// check, 32 flow-division steps, total update; a zero scale skips the first division, a saturated
// or zero-length window the last. Done waits out output stalls; input is taken only when idle.
// Asynchronous active-low reset sets configuration defaults, clears meter state and valid flag.
`timescale 1ns / 1ps
`include "pulse_flow_meter_defines.svh"

module pulse_flow_meter
  import pfm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CIDX_W-1:0]   cfg_index_i,
  input  logic [CDAT_W-1:0]   cfg_data_i,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [TIME_W-1:0]   timestamp_us_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                edge_accepted_o,
  output logic [CNT32_W-1:0]  pending_pulses_o,
  output logic [CNT32_W-1:0]  window_count_o,
  output logic [FLOW_W-1:0]   flow_q16_o,
  output logic [TOT_W-1:0]    total_liters_q16_o
);

  // Configuration registers.
  logic [CNT32_W-1:0] glitch_q;
  logic [SMPL_W-1:0]  sample_q;
  logic [PPL_W-1:0]   ppl_q;
  logic               win_en_q;

  // Architectural state of the meter.
  logic [TIME_W-1:0]  last_edge_q;
  logic [CNT32_W-1:0] pend_q;
  logic [TIME_W-1:0]  last_win_q;
  logic [CNT32_W-1:0] win_pulses_q;
  logic [FLOW_W-1:0]  flow_q;
  logic [TOT_W-1:0]   total_q;
  logic               edge_acc_q;

  // Sequencer and working registers.
  pfm_state_e         state_q, state_d;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  dt_q;
  // Holds the liter dividend while it shifts out, and the quotient as it shifts in.
  logic [LIT_W-1:0]   lit_q;
  // Holds the product; its low word later becomes the flow quotient.
  logic [PROD_W-1:0]  acc_q;
  // Partial remainder of whichever division is running.
  logic [TIME_W-1:0]  rem_q;
  logic [CNT_W-1:0]   cnt_q;

  // Result register.
  logic               out_valid_q;
  logic               out_edge_q;
  logic [CNT32_W-1:0] out_pend_q;
  logic [CNT32_W-1:0] out_win_q;
  logic [FLOW_W-1:0]  out_flow_q;
  logic [TOT_W-1:0]   out_total_q;

  // Shared adder. Subtraction is done as a + ~b + 1, and the carry out then means a >= b.
  logic [ALU_W-1:0]   alu_a;
  logic [ALU_W-1:0]   alu_b;
  logic               alu_cin;
  logic [ALU_W:0]     alu_sum;
  logic               alu_ge;

  logic               in_accept;
  logic               out_free;
  logic               edge_pass;
  logic               tot_sat;
  logic [FDT_W-1:0]   first_dt;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  // The result register can load when it is empty or is being emptied in this cycle.
  assign out_free    = !out_valid_q || !out_stall_i;

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (ALU_W + 1)'(alu_cin);
  assign alu_ge  = alu_sum[ALU_W];

  // An edge passes when the wrapped time since the last accepted edge exceeds the limit.
  assign edge_pass = alu_sum[TIME_W-1:0] > TIME_W'(glitch_q);
  // The total saturates once total plus liters reaches the all-ones value.
  assign tot_sat   = (|alu_sum[LIT_W:TOT_W]) || (&alu_sum[TOT_W-1:0]);
  // Length of a window that has no predecessor.
  assign first_dt  = FDT_W'(sample_q) * US_PER_MS;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (cmd_i == CMD_EDGE) begin
            state_d = ST_EDGE;
          end else if (cmd_i == CMD_WINDOW && win_en_q) begin
            state_d = ST_DT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_EDGE: state_d = ST_DONE;
      ST_DT: begin
        // Without a pulse scale the liters are zero and the division is skipped.
        state_d = (ppl_q == '0) ? ST_MUL : ST_DIV_L;
      end
      ST_DIV_L: begin
        if (cnt_q == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_q == '0) begin
          state_d = ST_OVF;
        end
      end
      ST_OVF: begin
        // A zero window gives zero flow; a high product word at or above dt saturates.
        state_d = (dt_q == '0 || alu_ge) ? ST_TOTAL : ST_DIV_F;
      end
      ST_DIV_F: begin
        if (cnt_q == '0) begin
          state_d = ST_TOTAL;
        end
      end
      ST_TOTAL: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Operand selection for the shared adder, driven by the sequencer state.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (state_q)
      ST_EDGE: begin
        alu_a   = ALU_W'(now_q);
        alu_b   = ~ALU_W'(last_edge_q);
        alu_cin = 1'b1;
      end
      ST_DT: begin
        alu_a   = ALU_W'(now_q);
        alu_b   = ~ALU_W'(last_win_q);
        alu_cin = 1'b1;
      end
      ST_DIV_L: begin
        alu_a   = ALU_W'({rem_q[PPL_W-1:0], lit_q[LIT_W-1]});
        alu_b   = ~ALU_W'(ppl_q);
        alu_cin = 1'b1;
      end
      ST_MUL: begin
        // Shift-and-add over the constant, most significant bit first.
        alu_a = {acc_q[PROD_W-2:0], 1'b0};
        alu_b = US_PER_MIN[cnt_q[$clog2(K_W)-1:0]] ? ALU_W'(lit_q) : '0;
      end
      ST_OVF: begin
        alu_a   = ALU_W'(acc_q[PROD_W-1:FLOW_W]);
        alu_b   = ~ALU_W'(dt_q);
        alu_cin = 1'b1;
      end
      ST_DIV_F: begin
        alu_a   = ALU_W'({rem_q, acc_q[FLOW_W-1]});
        alu_b   = ~ALU_W'(dt_q);
        alu_cin = 1'b1;
      end
      ST_TOTAL: begin
        alu_a = ALU_W'(total_q);
        alu_b = ALU_W'(lit_q);
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
      end
    endcase
  end

  // Sequencer state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      glitch_q <= '0;
      sample_q <= SMPL_W'(1000);
      ppl_q    <= '0;
      win_en_q <= 1'b1;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_GLITCH: glitch_q <= cfg_data_i;
          REG_SAMPLE: sample_q <= cfg_data_i[SMPL_W-1:0];
          REG_PPL:    ppl_q    <= cfg_data_i[PPL_W-1:0];
          REG_WIN_EN: win_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Meter state: counts, window history, flow and total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q  <= '0;
      pend_q       <= '0;
      last_win_q   <= '0;
      win_pulses_q <= '0;
      flow_q       <= '0;
      total_q      <= '0;
      edge_acc_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            edge_acc_q <= 1'b0;
            // The clear command keeps the last edge time so that the filter stays armed.
            if (cmd_i == CMD_CLEAR) begin
              pend_q       <= '0;
              last_win_q   <= '0;
              win_pulses_q <= '0;
              flow_q       <= '0;
              total_q      <= '0;
            end
          end
        end
        ST_EDGE: begin
          if (edge_pass) begin
            pend_q      <= pend_q + CNT32_W'(1);
            last_edge_q <= now_q;
            edge_acc_q  <= 1'b1;
          end
        end
        ST_DT: begin
          win_pulses_q <= pend_q;
          pend_q       <= '0;
          last_win_q   <= now_q;
        end
        ST_OVF: begin
          if (dt_q == '0) begin
            flow_q <= '0;
          end else if (alu_ge) begin
            flow_q <= FLOW_MAX;
          end
        end
        ST_DIV_F: begin
          if (cnt_q == '0) begin
            flow_q <= {acc_q[FLOW_W-2:0], alu_ge};
          end
        end
        ST_TOTAL: begin
          total_q <= tot_sat ? TOTAL_MAX : alu_sum[TOT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Working registers of the arithmetic sequence.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          now_q <= timestamp_us_i;
        end
      end
      ST_DT: begin
        // A window with no predecessor takes the configured first-window length.
        dt_q  <= (last_win_q == '0) ? TIME_W'(first_dt) : alu_sum[TIME_W-1:0];
        acc_q <= '0;
        rem_q <= '0;
        if (ppl_q == '0) begin
          lit_q <= '0;
          cnt_q <= MUL_LAST;
        end else begin
          lit_q <= {pend_q, {PPL_W{1'b0}}};
          cnt_q <= DIV_L_LAST;
        end
      end
      ST_DIV_L: begin
        // The remainder stays below the 24-bit divisor.
        if (alu_ge) begin
          rem_q <= TIME_W'(alu_sum[PPL_W-1:0]);
        end else begin
          rem_q <= TIME_W'({rem_q[PPL_W-2:0], lit_q[LIT_W-1]});
        end
        lit_q <= {lit_q[LIT_W-2:0], alu_ge};
        cnt_q <= (cnt_q == '0) ? MUL_LAST : cnt_q - CNT_W'(1);
      end
      ST_MUL: begin
        acc_q <= alu_sum[PROD_W-1:0];
        cnt_q <= cnt_q - CNT_W'(1);
      end
      ST_OVF: begin
        // When no saturation occurs, the high product word is below dt and seeds the remainder.
        rem_q <= acc_q[FLOW_W+TIME_W-1:FLOW_W];
        cnt_q <= DIV_F_LAST;
      end
      ST_DIV_F: begin
        if (alu_ge) begin
          rem_q <= alu_sum[TIME_W-1:0];
        end else begin
          rem_q <= {rem_q[TIME_W-2:0], acc_q[FLOW_W-1]};
        end
        acc_q[FLOW_W-1:0] <= {acc_q[FLOW_W-2:0], alu_ge};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, captured from the state once the sequence has finished.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_edge_q  <= edge_acc_q;
      out_pend_q  <= pend_q;
      out_win_q   <= win_pulses_q;
      out_flow_q  <= flow_q;
      out_total_q <= total_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign edge_accepted_o    = out_edge_q;
  assign pending_pulses_o   = out_pend_q;
  assign window_count_o     = out_win_q;
  assign flow_q16_o         = out_flow_q;
  assign total_liters_q16_o = out_total_q;

  // A result appears only at the end of a sequence.
  `PFM_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result without finished sequence")
  // The multiply counter never exceeds the index of the constant's top bit.
  `PFM_ASSERT_IMP(a_mul_cnt, state_q == ST_MUL, cnt_q <= MUL_LAST, "multiply counter out of range")
  // The pending count moves only on an edge check, a window or an accepted transaction.
  `PFM_ASSERT_IMP(a_pend_src, !$stable(pend_q), $past(state_q) == ST_EDGE || $past(state_q) == ST_DT || $past(in_accept), "pending count changed unexpectedly")

endmodule

FILE: tb/pfm_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the flow-meter pulse counter bench: it predicts the meter state
// bit for bit and queues the readings the block must return. Depends on pfm_pkg.

package pfm_tb_pkg;
  import pfm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;
  localparam logic [127:0]     USEC_PER_MINUTE = 128'd60_000_000;
  localparam logic [47:0]      USEC_PER_MSEC   = 48'd1000;
  localparam logic [31:0]      FLOW_SAT        = 32'hFFFF_FFFF;
  localparam logic [47:0]      TOTAL_SAT       = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        edge_ok;
    logic [31:0] pending;
    logic [31:0] window_pulses;
    logic [31:0] flow;
    logic [47:0] total;
  } meter_reading_t;

  class flow_meter_scoreboard;
    logic [31:0]    glitch_lim;
    logic [15:0]    first_ms;
    logic [23:0]    ppl_q8;
    logic           win_en;
    logic [47:0]    last_edge_us;
    logic [47:0]    prev_tick_us;
    logic [31:0]    pending;
    logic [31:0]    window_pulses;
    logic [31:0]    flow;
    logic [47:0]    total;
    meter_reading_t expected_readings[$];
    int unsigned    n_events, n_edges_ok, n_edges_filtered, n_windows, n_flow_sat;
    int unsigned    n_checked, n_errors;

    function new();
      glitch_lim       = '0;
      first_ms         = 16'd1000;
      ppl_q8           = '0;
      win_en           = 1'b1;
      last_edge_us     = '0;
      prev_tick_us     = '0;
      pending          = '0;
      window_pulses    = '0;
      flow             = '0;
      total            = '0;
      n_events         = 0;
      n_edges_ok       = 0;
      n_edges_filtered = 0;
      n_windows        = 0;
      n_flow_sat       = 0;
      n_checked        = 0;
      n_errors         = 0;
    endfunction

    // Registers keep only their own width of the write data.
    function void write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
      case (idx)
        REG_GLITCH: glitch_lim = data;
        REG_SAMPLE: first_ms   = data[15:0];
        REG_PPL:    ppl_q8     = data[23:0];
        REG_WIN_EN: win_en     = data[0];
        default: ;
      endcase
    endfunction

    function void take_window(logic [47:0] now);
      logic [47:0]  dt;
      logic [55:0]  liters;
      logic [127:0] quotient;
      n_windows++;
      // With no window taken yet the length comes from the first-window setting.
      dt = (prev_tick_us == '0) ? 48'(first_ms) * USEC_PER_MSEC : now - prev_tick_us;
      prev_tick_us  = now;
      window_pulses = pending;
      liters = (ppl_q8 != '0) ? {pending, 24'd0} / 56'(ppl_q8) : '0;
      pending = '0;
      if (dt != '0) begin
        quotient = 128'(liters) * USEC_PER_MINUTE / 128'(dt);
        if (quotient > 128'(FLOW_SAT)) begin
          flow = FLOW_SAT;
          n_flow_sat++;
        end else begin
          flow = quotient[31:0];
        end
      end else begin
        flow = '0;
      end
      if (64'(liters) >= 64'(TOTAL_SAT) - 64'(total)) begin
        total = TOTAL_SAT;
      end else begin
        total = total + liters[47:0];
      end
    endfunction

    // Called for every input transaction the block accepts.
    function void note_event(logic [CMD_W-1:0] cmd, logic [47:0] ts);
      logic           edge_ok;
      logic [47:0]    since;
      meter_reading_t want;
      edge_ok = 1'b0;
      n_events++;
      case (cmd)
        CMD_EDGE: begin
          since = ts - last_edge_us;
          if (since > 48'(glitch_lim)) begin
            pending      = pending + 32'd1;
            last_edge_us = ts;
            edge_ok      = 1'b1;
            n_edges_ok++;
          end else begin
            n_edges_filtered++;
          end
        end
        CMD_WINDOW: begin
          if (win_en) begin
            take_window(ts);
          end
        end
        CMD_CLEAR: begin
          // The filter keeps its last edge time across a clear.
          pending       = '0;
          total         = '0;
          window_pulses = '0;
          flow          = '0;
          prev_tick_us  = '0;
        end
        default: ;
      endcase
      want = '{edge_ok, pending, window_pulses, flow, total};
      expected_readings.push_back(want);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        n_errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_reading(meter_reading_t got);
      meter_reading_t want;
      if (expected_readings.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, got 0x%0h", $time, got);
        return;
      end
      want = expected_readings.pop_front();
      n_checked++;
      compare_field("edge_accepted", 64'(want.edge_ok), 64'(got.edge_ok));
      compare_field("pending_pulses", 64'(want.pending), 64'(got.pending));
      compare_field("window_count", 64'(want.window_pulses), 64'(got.window_pulses));
      compare_field("flow_q16", 64'(want.flow), 64'(got.flow));
      compare_field("total_liters_q16", 64'(want.total), 64'(got.total));
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Top-level bench for pulse_flow_meter: directed and random event streams under
// several register settings and idling patterns. Depends on pfm_pkg and pfm_tb_pkg.

module tb;
  import pfm_pkg::*;
  import pfm_tb_pkg::*;

  // Generous bound on the whole run; a correct run needs a small fraction of it.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned N_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS  = 240;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                cfg_valid_i        = 1'b0;
  logic                cfg_ready_o;
  logic [CIDX_W-1:0]   cfg_index_i        = REG_GLITCH;
  logic [CDAT_W-1:0]   cfg_data_i         = '0;
  logic                in_valid_i         = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    cmd_i              = CMD_EDGE;
  logic [TIME_W-1:0]   timestamp_us_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i        = 1'b0;
  logic                edge_accepted_o;
  logic [CNT32_W-1:0]  pending_pulses_o;
  logic [CNT32_W-1:0]  window_count_o;
  logic [FLOW_W-1:0]   flow_q16_o;
  logic [TOT_W-1:0]    total_liters_q16_o;

  flow_meter_scoreboard sb = new();

  // Idling knobs, in percent, changed by the stimulus between phases.
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  bit             hold_request   = 1'b0;
  int unsigned    hold_left      = 0;
  int unsigned    cycle_count    = 0;
  int unsigned    n_settings     = 0;
  logic [47:0]    now_us         = '0;
  meter_reading_t seen_reading;

  pulse_flow_meter uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .timestamp_us_i     (timestamp_us_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .edge_accepted_o    (edge_accepted_o),
    .pending_pulses_o   (pending_pulses_o),
    .window_count_o     (window_count_o),
    .flow_q16_o         (flow_q16_o),
    .total_liters_q16_o (total_liters_q16_o)
  );

  // 4 ns clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d readings outstanding.",
               sb.expected_readings.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side. Outputs are sampled at the edge, so the values seen here are the
  // ones the block presented for this edge. The stall for the next cycle is then
  // chosen: either a long hold-off that backs the block up into its input, or a
  // random stall at the rate of the current phase.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_reading = '{edge_accepted_o, pending_pulses_o, window_count_o, flow_q16_o,
                       total_liters_q16_o};
      sb.check_reading(seen_reading);
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Offers one input transaction and returns at the edge that accepts it. Valid is
  // left high on return, so back-to-back items never lower and raise it in one step;
  // it only drops in an idle cycle or before a register write.
  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [47:0] ts);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    timestamp_us_i <= ts;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_event(cmd, ts);
  endtask

  // One register write; the caller lowers valid after its last write.
  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Registers change only with the block idle: the input is withdrawn and every
  // expected reading must be back first. Every item yields a reading, so an empty
  // queue means nothing is in flight.
  task automatic write_settings(input logic [31:0] glitch_d, input logic [31:0] sample_d,
                                input logic [31:0] ppl_d, input logic [31:0] en_d);
    in_valid_i <= 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
    cfg_write(REG_GLITCH, glitch_d);
    cfg_write(REG_SAMPLE, sample_d);
    cfg_write(REG_PPL, ppl_d);
    cfg_write(REG_WIN_EN, en_d);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Spacing between sensor edges, scaled to the glitch window so that a fair share
  // of edges land on each side of it.
  function automatic logic [47:0] edge_step(input logic [31:0] glitch);
    logic [63:0] span;
    span = (glitch < 32'd1000) ? 64'd2000 : 2 * 64'(glitch) + 64'd2;
    return 48'({$urandom, $urandom} % span);
  endfunction

  // Window lengths: mostly realistic, sometimes 0 to 3 microseconds (the flow then tends to
  // saturate, and a zero length gives zero flow), sometimes very long.
  function automatic logic [47:0] window_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 48'($urandom_range(0, 3));
    end else if (r < 85) begin
      return 48'($urandom_range(1000, 2_000_000));
    end
    return 48'({$urandom, $urandom} & 64'hFF_FFFF_FFFF);
  endfunction

  // Random traffic is mostly well formed: a burst of edges followed by a window
  // tick, with clears, unused commands and time jumps (including across the 48-bit
  // wrap) mixed in. Unused commands are noise and do not count as items.
  task automatic run_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_edges;
    int unsigned r;
    sent = 0;
    while (sent < n_items) begin
      n_edges = $urandom_range(0, 12);
      repeat (n_edges) begin
        now_us = now_us + edge_step(sb.glitch_lim);
        send_event(CMD_EDGE, now_us);
      end
      now_us = now_us + window_gap();
      send_event(CMD_WINDOW, now_us);
      sent += n_edges + 1;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        now_us = now_us + 48'($urandom_range(0, 50));
        send_event(CMD_CLEAR, now_us);
        sent++;
      end else if (r < 10) begin
        send_event(CMD_UNUSED, 48'({$urandom, $urandom}));
      end else if (r < 14) begin
        now_us = 48'({$urandom, $urandom});
      end else if (r < 18) begin
        now_us = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 5000));
      end
    end
  endtask

  initial begin
    logic [31:0] glitch_d;
    logic [15:0] sample_v;
    logic [23:0] ppl_v;
    logic        en_v;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Junk in the upper data bits checks that each register keeps
    // only its own width.
    write_settings(32'd100, 32'hA5A5_03E8, 32'h7F01_C200, 32'hFFFF_FFF1);
    send_event(CMD_EDGE, 48'd0);                  // no time since the last edge
    send_event(CMD_EDGE, 48'd101);
    send_event(CMD_EDGE, 48'd201);                // exactly the glitch window: filtered
    send_event(CMD_EDGE, 48'd202);
    send_event(CMD_EDGE, 48'hFFFF_FFFF_FFFF);
    send_event(CMD_EDGE, 48'd50);                 // too close across the time wrap
    send_event(CMD_EDGE, 48'd200);                // far enough across the wrap
    send_event(CMD_WINDOW, 48'd0);                // tick at time zero: no predecessor after it
    send_event(CMD_EDGE, 48'd1000);
    send_event(CMD_WINDOW, 48'd1_000_000);        // first-window length again
    send_event(CMD_WINDOW, 48'd1_000_000);        // zero-length window
    send_event(CMD_UNUSED, 48'hAAAA_5555_AAAA);
    send_event(CMD_CLEAR, 48'h5555_AAAA_5555);

    // Widest glitch window, first-window length written as zero, pulse scale of 1 (256 liters per pulse).
    write_settings(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_0001, 32'h0000_0001);
    send_event(CMD_EDGE, 48'h1_0000_0000);
    send_event(CMD_EDGE, 48'h1_0000_03E8);
    send_event(CMD_WINDOW, 48'h8000_0000_0000);

    // Window ticks disabled: the pending count survives the tick.
    write_settings(32'd0, 32'd1, 32'd1, 32'h0000_0002);
    send_event(CMD_EDGE, 48'd10);
    send_event(CMD_EDGE, 48'd10);
    send_event(CMD_EDGE, 48'd11);
    send_event(CMD_WINDOW, 48'd20);

    // Re-enabled; a two-microsecond window drives the flow into saturation.
    write_settings(32'd0, 32'd1, 32'd1, 32'hFFFF_FFFF);
    send_event(CMD_WINDOW, 48'd21);
    send_event(CMD_EDGE, 48'd22);
    send_event(CMD_WINDOW, 48'd23);

    // Zero pulses per liter gives zero liters and zero flow.
    write_settings(32'd0, 32'd65535, 32'd0, 32'd1);
    send_event(CMD_EDGE, 48'd30);
    send_event(CMD_WINDOW, 48'd31);
    now_us = 48'd100;

    // Random phases. The idling pattern cycles through none, sender only, receiver
    // only and both; each phase begins from an idle block with fresh settings.
    for (int unsigned p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin glitch_d = 32'd50;          sample_v = 16'd1000;  ppl_v = 24'd115200;
                 en_v = 1'b1; end
        1: begin glitch_d = 32'd0;           sample_v = 16'd1;     ppl_v = 24'd1;
                 en_v = 1'b1; end
        2: begin glitch_d = 32'd2000;        sample_v = 16'd65535; ppl_v = 24'hFF_FFFF;
                 en_v = 1'b1; end
        3: begin glitch_d = 32'hFFFF_FFFF;   sample_v = 16'd250;   ppl_v = 24'd0;
                 en_v = 1'b1; end
        4: begin glitch_d = 32'd500;         sample_v = 16'd100;   ppl_v = 24'd1920;
                 en_v = 1'b0; end
        5: begin glitch_d = $urandom_range(0, 5000);
                 sample_v = 16'($urandom_range(1, 65535));
                 ppl_v = 24'($urandom);      en_v = 1'b1; end
        6: begin glitch_d = 32'd10;          sample_v = 16'd1000;  ppl_v = 24'd256;
                 en_v = 1'b1; end
        default: begin glitch_d = $urandom;  sample_v = 16'($urandom);
                 ppl_v = 24'($urandom);      en_v = 1'($urandom); end
      endcase
      write_settings(glitch_d, {16'($urandom), sample_v}, {8'($urandom), ppl_v},
                     {31'($urandom), en_v});
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      // Once, the receiver holds off for a long stretch while items keep coming.
      if (p == 2) begin
        hold_request = 1'b1;
      end
      run_random_traffic(PHASE_ITEMS);
    end

    in_valid_i <= 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d transactions under %0d register settings: %0d edges counted,",
             sb.n_events, n_settings, sb.n_edges_ok);
    $display("%0d edges filtered, %0d windows taken, %0d saturated flows, %0d results.",
             sb.n_edges_filtered, sb.n_windows, sb.n_flow_sat, sb.n_checked);
    if (sb.n_errors == 0 && sb.expected_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: pulse_flow_meter.f
+incdir+hw/rtl
hw/rtl/pfm_pkg.sv
hw/rtl/pulse_flow_meter.sv
tb/pfm_tb_pkg.sv
tb/tb.sv
